[design/bfma_pkg.sv]
// shared constants and the bfloat16 round-and-pack function
package bfma_pkg;

  localparam logic [15:0] QNAN = 16'h7FC0;
  localparam logic [7:0]  EXP_MAX = 8'hFF;
  localparam int unsigned NORM_W = 19;

  // round a nonzero significand to 8 bits and pack; biased exponent is ebias + msb index, plus one on rounding carry
  function automatic logic [15:0] round_pack(input logic sign,
                                             input logic signed [10:0] ebias,
                                             input logic [NORM_W-1:0] m);
    logic [4:0]        k;
    logic [NORM_W-1:0] mn;
    logic [8:0]        mant;
    logic              guard;
    logic              sticky;
    logic signed [10:0] be;
    k = '0;
    for (int i = 0; i < NORM_W; i++) begin
      if (m[i]) k = 5'(i);
    end
    mn = m << (5'(NORM_W - 1) - k);
    guard = mn[NORM_W-9];
    sticky = |mn[NORM_W-10:0];
    mant = {1'b0, mn[NORM_W-1:NORM_W-8]} + 9'(guard && (sticky || mn[NORM_W-8]));
    be = ebias + 11'(k) + 11'(mant[8]);
    if (be >= 11'sd255) begin
      return {sign, EXP_MAX, 7'd0};
    end else if (be <= 11'sd0) begin
      return {sign, 15'd0};
    end else begin
      return {sign, be[7:0], mant[8] ? 7'd0 : mant[6:0]};
    end
  endfunction

endpackage

[design/bf16_multiply_then_add.sv]
// unfused bfloat16 multiply then add, two register stages
// an input transfer is registered in stage one, then in the result register
// throughput: one item per cycle while out_ready is high; an 8x8 multiply feeds stage one, the aligned add stage two
// stalls back up stage by stage through the ready chain, no bubbles while out_ready is high
// reset (rst, synchronous) empties both stages; no other state
module bf16_multiply_then_add (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] a_bits,
  input  logic [15:0] b_bits,
  input  logic [15:0] c_bits,
  input  logic        last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] sum_bits,
  output logic        last_out
);

  logic        v1;
  logic [15:0] p;
  logic [15:0] c1;
  logic        last1;
  logic        adv1;
  logic        adv2;
  logic [15:0] p_next;
  logic [15:0] sum_next;

  // pipeline advance
  assign adv2 = !out_valid || out_ready;
  assign adv1 = !v1 || adv2;
  assign in_ready = adv1;

  // product rounded to bfloat16
  always_comb begin
    logic       s;
    logic [7:0] ea;
    logic [7:0] eb;
    logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [15:0] prod;
    s = a_bits[15] ^ b_bits[15];
    ea = a_bits[14:7];
    eb = b_bits[14:7];
    a_nan = (ea == bfma_pkg::EXP_MAX) && (a_bits[6:0] != 7'd0);
    b_nan = (eb == bfma_pkg::EXP_MAX) && (b_bits[6:0] != 7'd0);
    a_inf = (ea == bfma_pkg::EXP_MAX) && (a_bits[6:0] == 7'd0);
    b_inf = (eb == bfma_pkg::EXP_MAX) && (b_bits[6:0] == 7'd0);
    a_zero = (ea == 8'd0);
    b_zero = (eb == 8'd0);
    prod = {8'd0, 1'b1, a_bits[6:0]} * {8'd0, 1'b1, b_bits[6:0]};
    if (a_nan || b_nan) begin
      p_next = bfma_pkg::QNAN;
    end else if (a_inf || b_inf) begin
      p_next = (a_zero || b_zero) ? bfma_pkg::QNAN : {s, bfma_pkg::EXP_MAX, 7'd0};
    end else if (a_zero || b_zero) begin
      p_next = {s, 15'd0};
    end else begin
      p_next = bfma_pkg::round_pack(s, 11'(ea) + 11'(eb) - 11'sd144, {prod, 3'd0});
    end
  end

  // stage one registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
    if (adv1 && in_valid) begin
      p <= p_next;
      c1 <= c_bits;
      last1 <= last_in;
    end
  end

  // add of rounded product and addend
  always_comb begin
    logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
    logic [15:0] big;
    logic [15:0] sml;
    logic [7:0]  d;
    logic [17:0] mb;
    logic [17:0] ms;
    logic [17:0] lostmask;
    logic [18:0] acc;
    x_nan = (p[14:7] == bfma_pkg::EXP_MAX) && (p[6:0] != 7'd0);
    y_nan = (c1[14:7] == bfma_pkg::EXP_MAX) && (c1[6:0] != 7'd0);
    x_inf = (p[14:7] == bfma_pkg::EXP_MAX) && (p[6:0] == 7'd0);
    y_inf = (c1[14:7] == bfma_pkg::EXP_MAX) && (c1[6:0] == 7'd0);
    x_zero = (p[14:7] == 8'd0);
    y_zero = (c1[14:7] == 8'd0);
    if (p[14:0] >= c1[14:0]) begin
      big = p;
      sml = c1;
    end else begin
      big = c1;
      sml = p;
    end
    d = big[14:7] - sml[14:7];
    mb = {1'b1, big[6:0], 10'd0};
    ms = {1'b1, sml[6:0], 10'd0};
    if (d > 8'd20) begin
      lostmask = '0;
      ms = 18'd1;
    end else if (d != 8'd0) begin
      lostmask = (18'd1 << d[4:0]) - 18'd1;
      ms = (ms >> d[4:0]) | 18'(|(ms & lostmask));
    end else begin
      lostmask = '0;
    end
    if (big[15] == sml[15]) begin
      acc = {1'b0, mb} + {1'b0, ms};
    end else begin
      acc = {1'b0, mb} - {1'b0, ms};
    end
    if (x_nan || y_nan) begin
      sum_next = bfma_pkg::QNAN;
    end else if (x_inf && y_inf) begin
      sum_next = (p[15] == c1[15]) ? p : bfma_pkg::QNAN;
    end else if (x_inf) begin
      sum_next = p;
    end else if (y_inf) begin
      sum_next = c1;
    end else if (x_zero && y_zero) begin
      sum_next = {p[15] & c1[15], 15'd0};
    end else if (x_zero) begin
      sum_next = c1;
    end else if (y_zero) begin
      sum_next = p;
    end else if (acc == 19'd0) begin
      sum_next = 16'd0;
    end else begin
      sum_next = bfma_pkg::round_pack(big[15], 11'(big[14:7]) - 11'sd17, acc);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= v1;
    end
    if (adv2 && v1) begin
      sum_bits <= sum_next;
      last_out <= last1;
    end
  end

  // checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !v1)
    else $error("pipeline not empty after reset");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && out_valid && !out_ready) |=> v1 && $stable(p) && $stable(last1))
    else $error("stage one lost data during stall");
  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    (v1 && adv2) |=> out_valid)
    else $error("stage one item not moved to result");

endmodule
